// ===== rtl/fsqrt_pkg.sv =====
// Package for the single-precision square root: widths, constants, stage record.
// No dependencies.
`timescale 1ns / 1ps
package fsqrt_pkg;
  localparam int unsigned RemW    = 28;
  localparam int unsigned RootW   = 25;
  localparam int unsigned CellN   = 25;

  localparam logic [31:0] ExpMask    = 32'h7f80_0000;
  localparam logic [31:0] FracMask   = 32'h007f_ffff;
  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'h7fc0_0000;
  localparam logic [31:0] HalfBias   = 32'h3f00_0000;

  // Data carried from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic              special;
    logic [31:0]       spec_word;
    logic              spec_inv;
    logic [7:0]        half;
    logic [RemW-1:0]   rem;
    logic [RemW-1:0]   sum;
    logic [RootW-1:0]  root;
  } stage_t;
endpackage

// ===== rtl/fsqrt_if.sv =====
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface fsqrt_if #(parameter int unsigned W = 32) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fsqrt_cell.sv =====
// One restoring square root cell: decides one root bit.
// Depends on fsqrt_pkg.
`timescale 1ns / 1ps
module fsqrt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [4:0]            bit_pos,
  input  fsqrt_pkg::stage_t     din,
  output fsqrt_pkg::stage_t     dout
);
  import fsqrt_pkg::*;
  logic [RemW-1:0] probe;
  logic [RemW-1:0] cand;
  stage_t          res;

  // Trial subtraction of sum plus probe from the partial remainder.
  always_comb begin
    probe = RemW'(1) << bit_pos;
    cand  = din.sum + probe;
    res   = din;
    if (cand <= din.rem) begin
      res.sum  = cand + probe;
      res.rem  = din.rem - cand;
      res.root = din.root | RootW'(probe);
    end
    res.rem = res.rem << 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.special   <= res.special;
      dout.spec_word <= res.spec_word;
      dout.spec_inv  <= res.spec_inv;
      dout.half      <= res.half;
      dout.rem       <= res.rem;
      dout.sum       <= res.sum;
      dout.root      <= res.root;
    end
  end
endmodule

// ===== rtl/fsqrt_prep.sv =====
// Operand decode: special cases, subnormal normalization, exponent halving.
// Depends on fsqrt_pkg.
`timescale 1ns / 1ps
module fsqrt_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [31:0]       w,
  output fsqrt_pkg::stage_t dout
);
  import fsqrt_pkg::*;
  logic [4:0]  lz;
  logic [23:0] sig;
  logic [9:0]  e;
  logic        found;
  stage_t      res;

  // Leading-one search over the 23 fraction bits of a subnormal.
  always_comb begin
    lz = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && w[i]) begin
        found = 1'b1;
        lz = 5'(23 - i);
      end
    end
  end

  always_comb begin
    res = '0;
    res.vld = in_vld;
    if (w[30:23] == 8'hff) begin
      res.special = 1'b1;
      if (w[22:0] != 23'd0) begin
        res.spec_word = w | QuietBit;
        res.spec_inv  = ~w[22];
      end else if (w[31]) begin
        res.spec_word = DefaultNan;
        res.spec_inv  = 1'b1;
      end else begin
        res.spec_word = w;
      end
    end else if (w[30:0] == 31'd0) begin
      res.special   = 1'b1;
      res.spec_word = w;
    end else if (w[31]) begin
      res.special   = 1'b1;
      res.spec_word = DefaultNan;
      res.spec_inv  = 1'b1;
    end
    if (w[30:23] == 8'd0) begin
      sig = {1'b0, w[22:0]} << lz;
      e   = 10'sd1 - 10'(lz) - 10'd127;
    end else begin
      sig = {1'b1, w[22:0]};
      e   = 10'(w[30:23]) - 10'd127;
    end
    sig[23] = 1'b1;
    res.half = 8'($signed(e) >>> 1);
    res.rem  = e[0] ? {2'b0, sig, 2'b0} : {3'b0, sig, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= res.vld;
    end
    if (en) begin
      dout.special   <= res.special;
      dout.spec_word <= res.spec_word;
      dout.spec_inv  <= res.spec_inv;
      dout.half      <= res.half;
      dout.rem       <= res.rem;
      dout.sum       <= res.sum;
      dout.root      <= res.root;
    end
  end
endmodule

// ===== rtl/float32_square_root.sv =====
// Top level of the pipelined single-precision square root.
// Depends on fsqrt_pkg, fsqrt_if, fsqrt_prep and fsqrt_cell.
//
//  channel  | dir | payload
//  operand  | in  | operand_word[31:0]
//  result   | out | {root_word, invalid_flag, inexact_flag} = data[33:0]
//
// One transaction per cycle while the result is not stalled; stages are decode, 25 root cells and output.
// The whole pipeline advances together; a stall on the result holds every stage.
// rst is synchronous and clears only the stage valid bits.
`timescale 1ns / 1ps
module float32_square_root (
  input logic   clk,
  input logic   rst,
  fsqrt_if.sink operand,
  fsqrt_if.source result
);
  import fsqrt_pkg::*;
  stage_t      st [0:CellN];
  logic        en;
  logic        out_vld;
  logic [33:0] out_data;
  logic [31:0] fin_word;
  logic        fin_inx;
  logic [RootW-1:0] rnd;

  assign en = !out_vld || result.ready;
  assign operand.ready = en;

  fsqrt_prep u_prep (.clk(clk), .rst(rst), .en(en), .in_vld(operand.valid),
                     .w(operand.data[31:0]), .dout(st[0]));

  // Chain of root cells, most significant bit first.
  for (genvar g = 0; g < CellN; g++) begin : g_cell
    fsqrt_cell u_cell (.clk(clk), .rst(rst), .en(en), .bit_pos(5'(CellN - 1 - g)),
                       .din(st[g]), .dout(st[g+1]));
  end

  // Rounding and packing; the halved exponent is signed and is sign-extended.
  always_comb begin
    fin_inx  = st[CellN].rem != '0;
    rnd      = st[CellN].root + RootW'(fin_inx & st[CellN].root[0]);
    fin_word = 32'(rnd >> 1) + HalfBias
             + {st[CellN].half[7], st[CellN].half, 23'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= st[CellN].vld;
    end
    if (en) begin
      if (st[CellN].special) begin
        out_data <= {st[CellN].spec_word, st[CellN].spec_inv, 1'b0};
      end else begin
        out_data <= {fin_word, 1'b0, fin_inx};
      end
    end
  end

  assign result.valid = out_vld;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !result.ready |=> out_vld && $stable(out_data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_vld |-> operand.ready)
    else $error("input blocked with empty output");
  a_special_flags: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_data[1] |-> !out_data[0])
    else $error("invalid and inexact both set");
`endif
endmodule
